### hw/rtl/pshp_pkg.sv
// ----------------------------------------------------------------------------
// pshp_pkg
// Types and constants shared by the PC-sample histogram profiler modules.
// ----------------------------------------------------------------------------
package pshp_pkg;

  // Input item kinds
  localparam logic [2:0] KIND_TICK        = 3'd0;
  localparam logic [2:0] KIND_START       = 3'd1;
  localparam logic [2:0] KIND_START_CLEAR = 3'd2;
  localparam logic [2:0] KIND_STOP        = 3'd3;
  localparam logic [2:0] KIND_READ        = 3'd4;

  // Result status codes
  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_BEYOND = 2'd1;
  localparam logic [1:0] STATUS_BAD    = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PC      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PC      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_US_PER_TICK = 2'd2;

  // Header layout
  localparam int unsigned HDR_CELLS   = 6;
  localparam int unsigned CELL_TOTAL  = 0;
  localparam int unsigned CELL_OUTSIDE = 1;
  localparam int unsigned CELL_US     = 2;
  localparam int unsigned CELL_NBUF   = 3;
  localparam int unsigned CELL_SIZE   = 4;
  localparam int unsigned CELL_LOG    = 5;
  localparam logic [31:0] CELL_BYTES  = 32'd4;
  localparam logic [31:0] US_PER_TICK_RST = 32'd1000;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] pc;
    logic [11:0] word_index;
    logic [4:0]  read_count;
  } in_item_t;

  typedef struct packed {
    logic [31:0] data;
    logic [1:0]  status;
    logic        last;
  } out_item_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic       load_item;
    logic       set_en;
    logic       clr_en;
    logic       clr_start;
    logic       clr_step;
    logic       tick_eval;
    logic       tick_rd;
    logic       tick_wr;
    logic       rd_setup;
    logic       rd_issue;
    logic       out_load;
    logic       out_word;
    logic [1:0] out_status;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic [2:0] kind;
    logic       enabled;
    logic       in_bucket;
    logic       rd_beyond;
    logic       rd_last;
    logic       sweep_last;
    logic       out_free;
  } sts_t;

endpackage

### hw/rtl/pc_sample_histogram_profiler_top.sv
// ----------------------------------------------------------------------------
// pc_sample_histogram_profiler_top
// Sampling profiler histogram: counts ticks per program-counter bucket in a
// count table with a six-cell header, and reads the table back in bursts.
//
//   channel | ports                               | transfer when
//   --------+-------------------------------------+-------------------------
//   input   | in_valid, in_ready, in_item         | in_valid & in_ready
//   result  | out_valid, out_ready, out_item      | out_valid & out_ready
//   config  | cfg_valid, cfg_ready, cfg_index,    | cfg_valid & cfg_ready
//           | cfg_data                            |
//
// One item at a time: in_ready is high only in the idle state. A tick that
// lands in a bucket reads its cell and writes it back before its result; a
// read issues each word's table read and then sends that word, in turn.
// Start-with-clear and reset run a clearing sweep over all MAX_CELLS cells, one
// cell per cycle, during which no item is accepted; config is always taken.
// A stalled result register holds its value; the block waits for it.
// ----------------------------------------------------------------------------
module pc_sample_histogram_profiler_top import pshp_pkg::*; #(
  parameter int unsigned MAX_CELLS      = 4096,
  parameter int unsigned LOG_BUCKET     = 3,
  parameter int unsigned MAX_READ_WORDS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  pshp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pshp_datapath #(
    .MAX_CELLS      (MAX_CELLS),
    .LOG_BUCKET     (LOG_BUCKET),
    .MAX_READ_WORDS (MAX_READ_WORDS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

### hw/rtl/pshp_datapath.sv
// ----------------------------------------------------------------------------
// pshp_datapath
// Count table memory, header and counter registers, configuration registers,
// range check, read window setup and the result register.
// ----------------------------------------------------------------------------
module pshp_datapath import pshp_pkg::*; #(
  parameter int unsigned MAX_CELLS      = 4096,
  parameter int unsigned LOG_BUCKET     = 3,
  parameter int unsigned MAX_READ_WORDS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  input  in_item_t             in_item,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_item
);

  localparam int unsigned AW = $clog2(MAX_CELLS);
  localparam int unsigned NW = $clog2(MAX_CELLS + 1);
  localparam int unsigned XW = (NW > 12) ? NW : 12;
  localparam int unsigned LW = $clog2(MAX_READ_WORDS + 1);
  localparam logic [32:0] LO_OFF = 33'(HDR_CELLS) << LOG_BUCKET;

  logic [31:0]    min_pc_r, max_pc_r, us_per_tick_r;
  logic [NW-1:0]  nbuf_r, nbuf_nxt;
  in_item_t       item_r;
  logic           enabled_r;
  logic [31:0]    total_r, outside_r;
  logic [31:0]    hdr_us_r;
  logic [NW-1:0]  hdr_nbuf_r;
  logic [AW-1:0]  sweep_r;
  logic [AW-1:0]  tick_idx_r;
  logic [AW-1:0]  rd_addr_r;
  logic [LW-1:0]  rd_left_r;
  logic [31:0]    mem_rdata_r;
  logic           out_valid_r;
  out_item_t      out_item_r;

  logic [31:0]    mem [MAX_CELLS];

  logic [31:0]    span, span_sh;
  logic [32:0]    lo;
  logic [31:0]    idx32;
  logic           in_bucket;
  logic [XW-1:0]  widx_x, nbuf_x, avail_x, cnt_x;
  logic           rd_beyond;
  logic           rd_last;
  logic           out_free;
  logic [31:0]    hdr_val;
  logic [31:0]    word_val;
  logic           mem_we, mem_re;
  logic [AW-1:0]  mem_wa, mem_ra;
  logic [31:0]    mem_wd;

  // Bucket count from the range registers, capped at the table depth
  always_comb begin
    span    = max_pc_r - min_pc_r;
    span_sh = span >> LOG_BUCKET;
    if (max_pc_r <= min_pc_r) begin
      nbuf_nxt = '0;
    end else if (span_sh > 32'(MAX_CELLS)) begin
      nbuf_nxt = NW'(MAX_CELLS);
    end else begin
      nbuf_nxt = span_sh[NW-1:0];
    end
  end

  // Range check and bucket index for a tick
  always_comb begin
    lo        = {1'b0, min_pc_r} + LO_OFF;
    idx32     = (item_r.pc - min_pc_r) >> LOG_BUCKET;
    in_bucket = ({1'b0, item_r.pc} >= lo) && (item_r.pc < max_pc_r) &&
                (idx32 < 32'(nbuf_r));
  end

  // Read window: clamp the count to the limit and to the table end
  always_comb begin
    widx_x    = XW'(item_r.word_index);
    nbuf_x    = XW'(nbuf_r);
    rd_beyond = widx_x >= nbuf_x;
    avail_x   = nbuf_x - widx_x;
    cnt_x     = (item_r.read_count == 5'd0) ? XW'(1) : XW'(item_r.read_count);
    if (cnt_x > XW'(MAX_READ_WORDS)) begin
      cnt_x = XW'(MAX_READ_WORDS);
    end
    if (cnt_x > avail_x) begin
      cnt_x = avail_x;
    end
  end

  assign rd_last  = rd_left_r == LW'(1);
  assign out_free = !out_valid_r || out_ready;

  // Header value written by the clearing sweep
  always_comb begin
    priority if (sweep_r == AW'(CELL_US)) begin
      hdr_val = hdr_us_r;
    end else if (sweep_r == AW'(CELL_NBUF)) begin
      hdr_val = 32'(hdr_nbuf_r);
    end else if (sweep_r == AW'(CELL_SIZE)) begin
      hdr_val = CELL_BYTES;
    end else if (sweep_r == AW'(CELL_LOG)) begin
      hdr_val = 32'(LOG_BUCKET);
    end else begin
      hdr_val = '0;
    end
  end

  // Cells 0 and 1 live in registers
  always_comb begin
    priority if (rd_addr_r == AW'(CELL_TOTAL)) begin
      word_val = total_r;
    end else if (rd_addr_r == AW'(CELL_OUTSIDE)) begin
      word_val = outside_r;
    end else begin
      word_val = mem_rdata_r;
    end
  end

  // Memory port selection
  assign mem_we = cmd.clr_step || cmd.tick_wr;
  assign mem_wa = cmd.clr_step ? sweep_r : tick_idx_r;
  assign mem_wd = cmd.clr_step ? hdr_val : (mem_rdata_r + 32'd1);
  assign mem_re = cmd.tick_rd || cmd.rd_issue;
  assign mem_ra = cmd.tick_rd ? tick_idx_r : rd_addr_r;

  // Count table
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_rdata_r <= mem[mem_ra];
    end
  end

  // Configuration and control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_pc_r      <= '0;
      max_pc_r      <= '0;
      us_per_tick_r <= US_PER_TICK_RST;
      nbuf_r        <= '0;
      enabled_r     <= 1'b0;
      total_r       <= '0;
      outside_r     <= '0;
      hdr_us_r      <= US_PER_TICK_RST;
      hdr_nbuf_r    <= '0;
      sweep_r       <= '0;
      rd_left_r     <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      nbuf_r <= nbuf_nxt;
      if (cfg_wr) begin
        unique case (cfg_index)
          CFG_MIN_PC:      min_pc_r      <= cfg_data;
          CFG_MAX_PC:      max_pc_r      <= cfg_data;
          CFG_US_PER_TICK: us_per_tick_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.set_en) begin
        enabled_r <= 1'b1;
      end else if (cmd.clr_en) begin
        enabled_r <= 1'b0;
      end
      // Start a clearing sweep: snapshot the header values
      if (cmd.clr_start) begin
        hdr_us_r   <= us_per_tick_r;
        hdr_nbuf_r <= nbuf_r;
        sweep_r    <= '0;
        total_r    <= '0;
        outside_r  <= '0;
      end else if (cmd.clr_step) begin
        sweep_r <= sweep_r + AW'(1);
      end
      // Count a tick
      if (cmd.tick_eval) begin
        total_r <= total_r + 32'd1;
        if (!in_bucket) begin
          outside_r <= outside_r + 32'd1;
        end
      end
      // Advance the read window on each word transfer
      if (cmd.rd_setup) begin
        rd_left_r <= cnt_x[LW-1:0];
      end else if (cmd.out_load && cmd.out_word) begin
        rd_left_r <= rd_left_r - LW'(1);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r <= in_item;
    end
    if (cmd.tick_eval) begin
      tick_idx_r <= idx32[AW-1:0];
    end
    if (cmd.rd_setup) begin
      rd_addr_r <= widx_x[AW-1:0];
    end else if (cmd.out_load && cmd.out_word) begin
      rd_addr_r <= rd_addr_r + AW'(1);
    end
    if (cmd.out_load) begin
      out_item_r.data   <= cmd.out_word ? word_val : 32'd0;
      out_item_r.status <= cmd.out_status;
      out_item_r.last   <= cmd.out_word ? rd_last : 1'b1;
    end
  end

  assign sts.kind       = item_r.kind;
  assign sts.enabled    = enabled_r;
  assign sts.in_bucket  = in_bucket;
  assign sts.rd_beyond  = rd_beyond;
  assign sts.rd_last    = rd_last;
  assign sts.sweep_last = sweep_r == AW'(MAX_CELLS - 1);
  assign sts.out_free   = out_free;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // A tick never writes into the header cells
  a_tick_wr_past_header: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.tick_wr |-> tick_idx_r >= AW'(HDR_CELLS))
    else $error("tick write into header cell");

  // A word read is only issued while words remain
  a_rd_left: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_issue |-> rd_left_r != '0)
    else $error("read issued with no words left");

  // The result register is loaded only when it is free
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> out_free)
    else $error("result register overwritten");

endmodule

### hw/rtl/pshp_ctrl.sv
// ----------------------------------------------------------------------------
// pshp_ctrl
// Controller state machine: sequences clearing sweeps, tick updates, reads
// and result transfers through commands to the datapath.
// ----------------------------------------------------------------------------
module pshp_ctrl import pshp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_TICK_RD,
    S_TICK_WR,
    S_RD_ISSUE,
    S_RD_OUT,
    S_RESP
  } state_t;

  state_t     state_r, state_nxt;
  logic       clr_resp_r, clr_resp_nxt;
  logic [1:0] resp_status_r, resp_status_nxt;

  assign in_ready = state_r == S_IDLE;

  // Next state and commands
  always_comb begin
    state_nxt       = state_r;
    clr_resp_nxt    = clr_resp_r;
    resp_status_nxt = resp_status_r;
    cmd             = '0;
    cmd.out_status  = STATUS_OK;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = clr_resp_r ? S_RESP : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        resp_status_nxt = STATUS_OK;
        state_nxt       = S_RESP;
        unique case (sts.kind)
          KIND_TICK: begin
            if (sts.enabled) begin
              cmd.tick_eval = 1'b1;
              if (sts.in_bucket) begin
                state_nxt = S_TICK_RD;
              end
            end
          end
          KIND_START: cmd.set_en = 1'b1;
          KIND_STOP:  cmd.clr_en = 1'b1;
          KIND_START_CLEAR: begin
            cmd.clr_start = 1'b1;
            cmd.set_en    = 1'b1;
            clr_resp_nxt  = 1'b1;
            state_nxt     = S_CLEAR;
          end
          KIND_READ: begin
            if (sts.rd_beyond) begin
              resp_status_nxt = STATUS_BEYOND;
            end else begin
              cmd.rd_setup = 1'b1;
              state_nxt    = S_RD_ISSUE;
            end
          end
          default: resp_status_nxt = STATUS_BAD;
        endcase
      end
      S_TICK_RD: begin
        cmd.tick_rd = 1'b1;
        state_nxt   = S_TICK_WR;
      end
      S_TICK_WR: begin
        cmd.tick_wr = 1'b1;
        state_nxt   = S_RESP;
      end
      S_RD_ISSUE: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_RD_OUT;
      end
      S_RD_OUT: begin
        // Hold the word until the result register is free
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_word = 1'b1;
          state_nxt    = sts.rd_last ? S_IDLE : S_RD_ISSUE;
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = resp_status_r;
          clr_resp_nxt   = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      clr_resp_r    <= 1'b0;
      resp_status_r <= STATUS_OK;
    end else begin
      state_r       <= state_nxt;
      clr_resp_r    <= clr_resp_nxt;
      resp_status_r <= resp_status_nxt;
    end
  end

  // No item is taken in while a clearing sweep runs
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR |-> !cmd.load_item)
    else $error("item accepted during clearing sweep");

  // An accepted item is dispatched in the next cycle
  a_dispatch_follows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_item |=> state_r == S_DISPATCH)
    else $error("accepted item not dispatched");

  // A tick memory write always follows its read
  a_tick_rmw: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.tick_rd |=> cmd.tick_wr)
    else $error("tick read without write back");

endmodule

### tb/sv/tb_pc_sample_histogram_profiler_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pc_sample_histogram_profiler_top
// Self-checking bench for the PC-sample histogram profiler. Sends ticks,
// commands and table reads over the input channel. Keeps its own copy of the
// count table and the enable flag, and checks every returned word in order,
// field by field. Register settings change between phases, with the block
// idle, and cover the empty, capped and top-of-address-space cases.
// ----------------------------------------------------------------------------
module tb_pc_sample_histogram_profiler_top;
  import pshp_pkg::*;

  localparam int unsigned N_CELLS     = 4096;
  localparam int unsigned LOG_BKT     = 3;
  localparam int unsigned BURST_MAX   = 16;
  localparam int unsigned SWEEP_GAP   = N_CELLS + 64;
  localparam int unsigned TAIL_GAP    = 64;
  localparam int unsigned RAND_PHASES = 4;
  localparam int unsigned PHASE_ITEMS = 82;
  localparam logic [2:0]  KIND_BAD_LO = 3'd5;
  localparam logic [2:0]  KIND_BAD_HI = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_item_t             in_item   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_item;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data  = '0;

  // Shadow of the count table, the enable flag and the registers
  logic [31:0] hist [N_CELLS];
  logic        prof_on;
  logic [31:0] lo_pc;
  logic [31:0] hi_pc;
  logic [31:0] tick_us;
  out_item_t   pending_words[$];
  int unsigned err_cnt = 0;
  bit          steady  = 1'b0;

  pc_sample_histogram_profiler_top #(
    .MAX_CELLS      (N_CELLS),
    .LOG_BUCKET     (LOG_BKT),
    .MAX_READ_WORDS (BURST_MAX)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("tb_pc_sample_histogram_profiler_top NOT OK");
    $finish;
  end

  // Number of buckets, also the end of the readable table
  function automatic logic [31:0] bucket_total();
    logic [31:0] n;
    if (hi_pc <= lo_pc) return 32'd0;
    n = (hi_pc - lo_pc) >> LOG_BKT;
    return (n > N_CELLS) ? N_CELLS : n;
  endfunction

  // Zero the table and rewrite the header from the current registers
  function automatic void rebuild_table();
    foreach (hist[i]) hist[i] = 32'd0;
    hist[CELL_US]   = tick_us;
    hist[CELL_NBUF] = bucket_total();
    hist[CELL_SIZE] = CELL_BYTES;
    hist[CELL_LOG]  = LOG_BKT;
  endfunction

  function automatic void expect_word(input logic [31:0] data, input logic [1:0] status,
                                      input logic last);
    pending_words.push_back(out_item_t'{data: data, status: status, last: last});
  endfunction

  // Advance the shadow state by one accepted item and queue its results
  function automatic void update_histogram(input in_item_t item);
    logic [32:0] floor_pc;
    logic [31:0] nb;
    logic [31:0] slot;
    int unsigned n;
    case (item.kind)
      KIND_TICK: begin
        if (prof_on) begin
          nb       = bucket_total();
          floor_pc = {1'b0, lo_pc} + 33'(HDR_CELLS << LOG_BKT);
          slot     = (item.pc - lo_pc) >> LOG_BKT;
          hist[CELL_TOTAL] += 32'd1;
          // header span is checked without wrap; buckets past the end count outside
          if (floor_pc <= {1'b0, item.pc} && item.pc < hi_pc && slot < nb)
            hist[slot] += 32'd1;
          else
            hist[CELL_OUTSIDE] += 32'd1;
        end
        expect_word(32'd0, STATUS_OK, 1'b1);
      end
      KIND_START: begin
        prof_on = 1'b1;
        expect_word(32'd0, STATUS_OK, 1'b1);
      end
      KIND_START_CLEAR: begin
        rebuild_table();
        prof_on = 1'b1;
        expect_word(32'd0, STATUS_OK, 1'b1);
      end
      KIND_STOP: begin
        prof_on = 1'b0;
        expect_word(32'd0, STATUS_OK, 1'b1);
      end
      KIND_READ: begin
        nb = bucket_total();
        if (item.word_index >= nb) begin
          expect_word(32'd0, STATUS_BEYOND, 1'b1);
        end else begin
          // zero means one word; clip to the burst size and the table end
          n = (item.read_count == 5'd0) ? 1 : item.read_count;
          if (n > BURST_MAX) n = BURST_MAX;
          if (n > nb - item.word_index) n = nb - item.word_index;
          for (int unsigned k = 0; k < n; k++)
            expect_word(hist[(item.word_index + k) % N_CELLS], STATUS_OK, k + 1 == n);
        end
      end
      default: begin
        expect_word(32'd0, STATUS_BAD, 1'b1);
      end
    endcase
  endfunction

  // Send one item, with an occasional gap in front of it
  task automatic issue_request(input logic [2:0] kind, input logic [31:0] pc,
                               input logic [11:0] widx, input logic [4:0] cnt);
    in_item_t item;
    item = '{kind: kind, pc: pc, word_index: widx, read_count: cnt};
    if (!steady && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    update_histogram(item);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_MIN_PC:      lo_pc   = val;
      CFG_MAX_PC:      hi_pc   = val;
      CFG_US_PER_TICK: tick_us = val;
      default: ;
    endcase
  endtask

  // Drop valid, wait for every expected word, then hold for the given cycles
  task automatic settle(input int unsigned gap);
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (gap) @(posedge clk);
  endtask

  // Reprogram the block once any clearing sweep has finished
  task automatic configure(input logic [31:0] min_v, input logic [31:0] max_v,
                           input logic [31:0] us_v);
    settle(SWEEP_GAP);
    write_reg(CFG_MIN_PC, min_v);
    write_reg(CFG_MAX_PC, max_v);
    write_reg(CFG_US_PER_TICK, us_v);
    write_reg(CFG_SPARE, $urandom);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_state();
    // stopped and no buckets: ticks do nothing, every read is past the end
    issue_request(KIND_TICK, 32'h0, 12'h0, 5'd1);
    issue_request(KIND_READ, 32'h0, 12'h0, 5'd1);
    issue_request(KIND_BAD_LO, 32'h0, 12'h0, 5'd0);
    issue_request(KIND_BAD_HI, 32'hFFFF_FFFF, 12'hFFF, 5'd31);
    issue_request(KIND_STOP, 32'h0, 12'h0, 5'd0);
  endtask

  task automatic test_start_keeps_table();
    configure(32'h0, 32'h400, 32'hFFFF_FFFF);
    issue_request(KIND_START, 32'h0, 12'h0, 5'd0);
    issue_request(KIND_TICK, 32'h100, 12'h0, 5'd0);
    issue_request(KIND_TICK, 32'h2F, 12'h0, 5'd0);
    issue_request(KIND_TICK, 32'h400, 12'h0, 5'd0);
    // reset header is still in place; oversized count is capped
    issue_request(KIND_READ, 32'h0, 12'd0, 5'd31);
    issue_request(KIND_READ, 32'h0, 12'd32, 5'd0);
    issue_request(KIND_STOP, 32'h0, 12'h0, 5'd0);
    issue_request(KIND_TICK, 32'h108, 12'h0, 5'd0);
  endtask

  task automatic test_clear_full_span();
    configure(32'h0, 32'hFFFF_FFFF, 32'h0);
    issue_request(KIND_START_CLEAR, 32'h0, 12'h0, 5'd0);
    issue_request(KIND_TICK, 32'h30, 12'h0, 5'd0);
    issue_request(KIND_TICK, 32'h7FF8, 12'h0, 5'd0);
    issue_request(KIND_TICK, 32'h8000, 12'h0, 5'd0);
    issue_request(KIND_TICK, 32'hFFFF_FFFE, 12'h0, 5'd0);
    issue_request(KIND_READ, 32'h0, 12'd4088, 5'd16);
    issue_request(KIND_READ, 32'h0, 12'd4095, 5'd1);
    issue_request(KIND_READ, 32'h0, 12'd0, 5'd6);
  endtask

  task automatic test_top_of_space();
    configure(32'hFFFF_FFF0, 32'hFFFF_FFFF, US_PER_TICK_RST);
    issue_request(KIND_START_CLEAR, 32'h0, 12'h0, 5'd0);
    issue_request(KIND_TICK, 32'hFFFF_FFF8, 12'h0, 5'd0);
    issue_request(KIND_READ, 32'h0, 12'd0, 5'd16);
    issue_request(KIND_READ, 32'h0, 12'd1, 5'd1);
  endtask

  task automatic test_random_traffic();
    logic [31:0] min_v;
    logic [31:0] max_v;
    logic [32:0] top;
    logic [31:0] span;
    logic [31:0] pc;
    logic [31:0] nb;
    logic [2:0]  kind;
    logic [11:0] widx;
    logic [4:0]  cnt;
    int unsigned roll;
    int unsigned hi_idx;
    for (int unsigned ph = 0; ph < RAND_PHASES; ph++) begin
      // one phase runs with neither side idling
      steady = (ph == 2);
      case ($urandom_range(7))
        0: begin
          min_v = $urandom;
          max_v = $urandom_range(0, min_v);
        end
        1: begin
          min_v = $urandom_range(0, 32'h1000);
          max_v = 32'hFFFF_FFFF - $urandom_range(0, 255);
        end
        default: begin
          min_v = $urandom;
          top   = {1'b0, min_v} + $urandom_range(8, 480);
          max_v = top[32] ? 32'hFFFF_FFFF : top[31:0];
        end
      endcase
      configure(min_v, max_v, $urandom);
      issue_request(KIND_START_CLEAR, $urandom, 12'($urandom), 5'($urandom));
      span = (max_v > min_v) ? max_v - min_v : 32'd64;
      if (span > 32'h8000) span = 32'h8000;
      for (int unsigned i = 1; i < PHASE_ITEMS; i++) begin
        roll   = $urandom_range(99);
        pc     = ($urandom_range(4) == 0) ? $urandom : min_v + $urandom_range(0, span + 16);
        nb     = bucket_total();
        hi_idx = (nb + 4 > N_CELLS - 1) ? N_CELLS - 1 : nb + 4;
        widx   = ($urandom_range(4) == 0) ? 12'($urandom) : 12'($urandom_range(0, hi_idx));
        cnt    = ($urandom_range(2) == 0) ? 5'($urandom) : 5'($urandom_range(1, BURST_MAX));
        if (roll < 55)      kind = KIND_TICK;
        else if (roll < 75) kind = KIND_READ;
        else if (roll < 83) kind = KIND_START;
        else if (roll < 89) kind = KIND_STOP;
        else if (roll < 92) kind = KIND_START_CLEAR;
        else                kind = 3'($urandom_range(KIND_BAD_LO, KIND_BAD_HI));
        issue_request(kind, pc, widx, cnt);
      end
    end
    steady = 1'b0;
  endtask

  function automatic void flag_field(input string name, input logic [31:0] exp_v,
                                     input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      err_cnt++;
      $error("%s: expected %h, got %h", name, exp_v, got_v);
    end
  endfunction

  // Check each result transfer against the oldest expectation; drive out_ready
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        err_cnt++;
        $error("result with nothing expected: data %h status %0d last %0d",
               out_item.data, out_item.status, out_item.last);
      end else begin
        want = pending_words.pop_front();
        flag_field("data", want.data, out_item.data);
        flag_field("status", 32'(want.status), 32'(out_item.status));
        flag_field("last", 32'(want.last), 32'(out_item.last));
      end
    end
    out_ready <= steady || ($urandom_range(99) >= 6);
  end

  initial begin
    lo_pc   = 32'd0;
    hi_pc   = 32'd0;
    tick_us = US_PER_TICK_RST;
    prof_on = 1'b0;
    rebuild_table();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_start_keeps_table();
    test_clear_full_span();
    test_top_of_space();
    test_random_traffic();
    settle(TAIL_GAP);
    if (err_cnt == 0)
      $display("tb_pc_sample_histogram_profiler_top OK");
    else
      $display("tb_pc_sample_histogram_profiler_top NOT OK");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/pshp_pkg.sv
hw/rtl/pshp_datapath.sv
hw/rtl/pshp_ctrl.sv
hw/rtl/pc_sample_histogram_profiler_top.sv
tb/sv/tb_pc_sample_histogram_profiler_top.sv
